/* sv/vna_pkg.sv */
// Shared constants, command/status types and state codes of the vertex normal accumulator.
package vna_pkg;

	localparam int VERTEX_COUNT = 4096;
	localparam int ADDR_W       = $clog2(VERTEX_COUNT);
	localparam int IDX_W        = 12;
	localparam int COORD_WIDTH  = 16;
	localparam int POS_W        = 3 * COORD_WIDTH;
	localparam int EDGE_W       = COORD_WIDTH + 1;
	localparam int FN_W         = 2 * EDGE_W + 1;
	localparam int ACC_W        = 40;
	localparam int MAG_W        = ACC_W;
	localparam int NRM_W        = 31;
	localparam int MUL_W        = 33;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int SUM_W        = 64;
	localparam int LEN_W        = SUM_W / 2;
	localparam int FRAC_OUT     = 14;
	localparam int Q_W          = FRAC_OUT + 1;
	localparam int DIV_W        = LEN_W + FRAC_OUT;
	localparam int OUT_W        = 16;
	localparam int IN_DATA_W    = 88;
	localparam int OUT_DATA_W   = 64;
	localparam int CNT_W        = (ADDR_W > 6) ? ADDR_W : 6;
	localparam int SQRT_STEPS   = SUM_W / 2;
	localparam int DIV_STEPS    = Q_W;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_TRI   = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [Q_W-1:0] ONE_Q = Q_W'(1 << FRAC_OUT);

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_TRI_RD,
		ST_TRI_EDGE,
		ST_TRI_MUL,
		ST_TRI_ACC_RD,
		ST_TRI_ACC_WR,
		ST_RD_ACC,
		ST_RD_CAP,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_DIV_LD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		MO_YZ, MO_ZY, MO_ZX, MO_XZ, MO_XY, MO_YX, MO_SQ0, MO_SQ1, MO_SQ2
	} mul_op_t;

	typedef enum logic [1:0] {
		CN_A, CN_B, CN_C
	} corner_t;

	typedef enum logic [1:0] {
		AS_CLR, AS_A, AS_B, AS_C
	} acc_sel_t;

	typedef struct packed {
		logic              load;
		logic              pos_we;
		corner_t           pos_sel;
		logic              pos_cap;
		logic              edge_ld;
		logic              mul_en;
		mul_op_t           mul_op;
		logic              sum_clr;
		acc_sel_t          acc_sel;
		logic [ADDR_W-1:0] clr_addr;
		logic              acc_we;
		logic              acc_zero;
		logic              mag_ld;
		logic              norm_step;
		logic              res_clr;
		logic              sqrt_ld;
		logic              sqrt_step;
		logic              div_ld;
		logic              div_step;
		logic [1:0]        comp;
		logic              res_st;
		logic              out_ld;
	} vna_cmd_t;

	typedef struct packed {
		logic norm_zero;
		logic norm_ok;
		logic out_busy;
	} vna_status_t;

endpackage

/* sv/vna_datapath.sv */
// Datapath: position and accumulator memories, shared multiplier, root and divide units.
module vna_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vna_pkg::vna_cmd_t             cmd,
	output vna_pkg::vna_status_t          st,
	input  logic [vna_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [vna_pkg::OUT_DATA_W-1:0] m_tdata
);
	import vna_pkg::*;

	logic [IDX_W-1:0]       a_q, b_q, c_q;
	logic [POS_W-1:0]       wpos_q;
	logic [POS_W-1:0]       pos_mem [VERTEX_COUNT];
	logic [POS_W-1:0]       pos_rd_q, pa_q, pb_q, pc_q;
	logic [ADDR_W-1:0]      pos_addr, acc_addr;
	logic [3*ACC_W-1:0]     acc_mem [VERTEX_COUNT];
	logic [3*ACC_W-1:0]     acc_rd_q, acc_wd;
	logic signed [EDGE_W-1:0] e1_q [3];
	logic signed [EDGE_W-1:0] e2_q [3];
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	mul_op_t                op_s1;
	logic                   vld_s1;
	logic signed [FN_W-1:0] fn_q [3];
	logic signed [FN_W-1:0] prod_fn;
	logic [SUM_W-1:0]       sum_q;
	logic [MAG_W-1:0]       mag_q [3];
	logic                   neg_q [3];
	logic [MAG_W-1:0]       mx01, mx;
	logic [SUM_W-1:0]       rem_q, root_q, sbit_q;
	logic [SUM_W:0]         trial;
	logic [LEN_W-1:0]       len;
	logic [DIV_W-1:0]       drem_q, dvs_q;
	logic [Q_W-1:0]         quo_q, quo_c;
	logic signed [OUT_W-1:0] res_q [3];
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	function automatic logic signed [EDGE_W-1:0] crd(input logic [POS_W-1:0] p,
			input int k);
		logic signed [COORD_WIDTH-1:0] v;
		v = p[k*COORD_WIDTH +: COORD_WIDTH];
		return EDGE_W'(v);
	endfunction

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
			input logic signed [FN_W-1:0] f);
		logic signed [ACC_W:0] s;
		s = $signed({acc[ACC_W-1], acc}) + (ACC_W+1)'(f);
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

	// latch the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= s_tdata[IDX_W-1:0];
			b_q    <= s_tdata[2*IDX_W-1:IDX_W];
			c_q    <= s_tdata[3*IDX_W-1:2*IDX_W];
			wpos_q <= s_tdata[3*IDX_W +: POS_W];
		end
	end

	always_comb begin
		case (cmd.pos_sel)
			CN_A:    pos_addr = a_q[ADDR_W-1:0];
			CN_B:    pos_addr = b_q[ADDR_W-1:0];
			CN_C:    pos_addr = c_q[ADDR_W-1:0];
			default: pos_addr = a_q[ADDR_W-1:0];
		endcase
		case (cmd.acc_sel)
			AS_CLR:  acc_addr = cmd.clr_addr;
			AS_A:    acc_addr = a_q[ADDR_W-1:0];
			AS_B:    acc_addr = b_q[ADDR_W-1:0];
			AS_C:    acc_addr = c_q[ADDR_W-1:0];
			default: acc_addr = cmd.clr_addr;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_we)
			pos_mem[pos_addr] <= wpos_q;
		pos_rd_q <= pos_mem[pos_addr];
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			acc_wd[k*ACC_W +: ACC_W] = cmd.acc_zero ? '0 :
				sat_add(acc_rd_q[k*ACC_W +: ACC_W], fn_q[k]);
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_we)
			acc_mem[acc_addr] <= acc_wd;
		acc_rd_q <= acc_mem[acc_addr];
	end

	// corners arrive a, b, c; shift them in
	always_ff @(posedge clk) begin
		if (cmd.pos_cap) begin
			pc_q <= pos_rd_q;
			pb_q <= pc_q;
			pa_q <= pb_q;
		end
		if (cmd.edge_ld) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= crd(pb_q, k) - crd(pa_q, k);
				e2_q[k] <= crd(pc_q, k) - crd(pa_q, k);
			end
		end
	end

	always_comb begin
		case (cmd.mul_op)
			MO_YZ:   begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
			MO_ZY:   begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
			MO_ZX:   begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
			MO_XZ:   begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
			MO_XY:   begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
			MO_YX:   begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
			MO_SQ0:  begin
				mul_a = $signed({2'b00, mag_q[0][NRM_W-1:0]});
				mul_b = mul_a;
			end
			MO_SQ1:  begin
				mul_a = $signed({2'b00, mag_q[1][NRM_W-1:0]});
				mul_b = mul_a;
			end
			MO_SQ2:  begin
				mul_a = $signed({2'b00, mag_q[2][NRM_W-1:0]});
				mul_b = mul_a;
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		op_s1   <= cmd.mul_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_en;
		end
	end

	assign prod_fn = prod_s1[FN_W-1:0];

	// fold each registered product into its cross component or the square sum
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			for (int k = 0; k < 3; k++)
				fn_q[k] <= '0;
			sum_q <= '0;
		end else if (vld_s1) begin
			case (op_s1)
				MO_YZ:   fn_q[0] <= fn_q[0] + prod_fn;
				MO_ZY:   fn_q[0] <= fn_q[0] - prod_fn;
				MO_ZX:   fn_q[1] <= fn_q[1] + prod_fn;
				MO_XZ:   fn_q[1] <= fn_q[1] - prod_fn;
				MO_XY:   fn_q[2] <= fn_q[2] + prod_fn;
				MO_YX:   fn_q[2] <= fn_q[2] - prod_fn;
				default: sum_q <= sum_q + prod_s1[SUM_W-1:0];
			endcase
		end
	end

	assign mx01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
	assign mx   = (mx01 > mag_q[2]) ? mx01 : mag_q[2];
	assign st.norm_zero = (mx == '0);
	assign st.norm_ok   = (mx[MAG_W-1:NRM_W] == '0) && mx[NRM_W-1];

	always_ff @(posedge clk) begin
		if (cmd.mag_ld) begin
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= acc_rd_q[k*ACC_W + ACC_W - 1];
				mag_q[k] <= acc_rd_q[k*ACC_W + ACC_W - 1] ?
					(MAG_W'(0) - acc_rd_q[k*ACC_W +: ACC_W]) : acc_rd_q[k*ACC_W +: ACC_W];
			end
		end else if (cmd.norm_step) begin
			for (int k = 0; k < 3; k++)
				mag_q[k] <= (mx[MAG_W-1:NRM_W] != '0) ? (mag_q[k] >> 1) : (mag_q[k] << 1);
		end
	end

	// one result bit of the square root per cycle
	assign trial = {1'b0, root_q} + {1'b0, sbit_q};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_ld) begin
			rem_q  <= sum_q;
			root_q <= '0;
			sbit_q <= SUM_W'(1) << (SUM_W - 2);
		end else if (cmd.sqrt_step) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q  <= rem_q - trial[SUM_W-1:0];
				root_q <= (root_q >> 1) + sbit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	assign len = root_q[LEN_W-1:0];

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_ld) begin
			drem_q <= {DIV_W'(mag_q[cmd.comp][NRM_W-1:0]) << FRAC_OUT} + DIV_W'(len >> 1);
			dvs_q  <= {len, {FRAC_OUT{1'b0}}};
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			if (drem_q >= dvs_q) begin
				drem_q <= drem_q - dvs_q;
				quo_q  <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				quo_q  <= {quo_q[Q_W-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
	end

	assign quo_c = (quo_q > ONE_Q) ? ONE_Q : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.res_clr) begin
			for (int k = 0; k < 3; k++)
				res_q[k] <= '0;
		end else if (cmd.res_st) begin
			res_q[cmd.comp] <= neg_q[cmd.comp] ? (OUT_W'(0) - OUT_W'(quo_c)) : OUT_W'(quo_c);
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld)
			out_data_q <= {{(OUT_DATA_W - IDX_W - 3*OUT_W){1'b0}},
				res_q[2], res_q[1], res_q[0], a_q};
	end

	assign st.out_busy = out_valid_q & ~m_tready;
	assign m_tvalid    = out_valid_q;
	assign m_tdata     = out_data_q;

endmodule

/* sv/vna_ctrl.sv */
// Controller: sequences clearing, vertex writes, triangle accumulation and normal reads.
module vna_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [1:0]           mode,
	input  vna_pkg::vna_status_t st,
	output vna_pkg::vna_cmd_t    cmd
);
	import vna_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       comp_q, comp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			comp_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		comp_d       = comp_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.pos_sel  = CN_A;
		cmd.acc_sel  = AS_A;
		cmd.mul_op   = MO_YZ;
		cmd.clr_addr = cnt_q[ADDR_W-1:0];
		cmd.comp     = comp_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.acc_sel  = AS_CLR;
				cmd.acc_we   = 1'b1;
				cmd.acc_zero = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VERTEX_COUNT - 1)) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				cnt_d    = '0;
				comp_d   = '0;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					case (mode)
						MODE_WRITE: state_d = ST_WRITE;
						MODE_TRI:   state_d = ST_TRI_RD;
						MODE_READ:  state_d = ST_RD_ACC;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: begin
				cmd.pos_we   = 1'b1;
				cmd.acc_we   = 1'b1;
				cmd.acc_zero = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_TRI_RD: begin
				// read a, b, c back to back; capture each in the cycle after its read
				cmd.pos_sel = corner_t'(cnt_q[1:0]);
				cmd.pos_cap = (cnt_q != '0);
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(3)) begin
					cnt_d   = '0;
					state_d = ST_TRI_EDGE;
				end
			end
			ST_TRI_EDGE: begin
				cmd.edge_ld = 1'b1;
				cmd.sum_clr = 1'b1;
				state_d     = ST_TRI_MUL;
			end
			ST_TRI_MUL: begin
				cmd.mul_op = mul_op_t'(cnt_q[3:0]);
				cmd.mul_en = (cnt_q < CNT_W'(6));
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(6)) begin
					cnt_d   = '0;
					comp_d  = '0;
					state_d = ST_TRI_ACC_RD;
				end
			end
			ST_TRI_ACC_RD: begin
				cmd.acc_sel = acc_sel_t'(comp_q + 2'd1);
				state_d     = ST_TRI_ACC_WR;
			end
			ST_TRI_ACC_WR: begin
				cmd.acc_sel = acc_sel_t'(comp_q + 2'd1);
				cmd.acc_we  = 1'b1;
				comp_d      = comp_q + 2'd1;
				state_d     = (comp_q == 2'd2) ? ST_IDLE : ST_TRI_ACC_RD;
			end
			ST_RD_ACC: begin
				state_d = ST_RD_CAP;
			end
			ST_RD_CAP: begin
				cmd.mag_ld = 1'b1;
				state_d    = ST_NORM;
			end
			ST_NORM: begin
				if (st.norm_zero) begin
					cmd.res_clr = 1'b1;
					state_d     = ST_OUT;
				end else if (st.norm_ok) begin
					cmd.sum_clr = 1'b1;
					cnt_d       = '0;
					state_d     = ST_SQ;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			ST_SQ: begin
				cmd.mul_op = mul_op_t'(cnt_q[3:0] + 4'd6);
				cmd.mul_en = (cnt_q < CNT_W'(3));
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(3)) begin
					cnt_d   = '0;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_ld   = (cnt_q == '0);
				cmd.sqrt_step = (cnt_q != '0);
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_STEPS)) begin
					cnt_d   = '0;
					comp_d  = '0;
					state_d = ST_DIV_LD;
				end
			end
			ST_DIV_LD: begin
				cmd.div_ld = 1'b1;
				cnt_d      = '0;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = (cnt_q < CNT_W'(DIV_STEPS));
				cmd.res_st   = (cnt_q == CNT_W'(DIV_STEPS));
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS)) begin
					cnt_d   = '0;
					comp_d  = comp_q + 2'd1;
					state_d = (comp_q == 2'd2) ? ST_OUT : ST_DIV_LD;
				end
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!st.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !st.out_busy)
		else $error("result loaded over an untaken result");

	a_div_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_LD) |=> (state_q == ST_DIV))
		else $error("divide load not followed by divide steps");

	a_norm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		st.norm_zero |-> !st.norm_ok)
		else $error("zero vector reported as normalised");

	a_write_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> $past(state_q == ST_IDLE))
		else $error("vertex write entered outside idle");

endmodule

/* sv/vertex_normal_accumulator_top.sv */
// Top level of the area-weighted vertex normal accumulator.
// After reset the accumulator memory is swept to zero, one vertex a cycle, with s_tready
// low. Reset is asynchronous, active low, and clears all control state.
// A triangle is paced by the single position read port, the one shared multiplier (six
// cross products) and read-modify-write of three corners. A normal read is paced by a
// bit-a-cycle normalising shift, a 32-step square root and three 15-step divides, all
// skipped for a zero vector; the result leaves through an output register, and a result
// still waiting there holds the next read in its last state.
module vertex_normal_accumulator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// vertex_a[11:0], vertex_b[23:12], vertex_c[35:24], pos_x[51:36], pos_y[67:52],
	// pos_z[83:68], zero fill
	input  logic [vna_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// vertex_index[11:0], normal_x[27:12], normal_y[43:28], normal_z[59:44], zero fill
	output logic [vna_pkg::OUT_DATA_W-1:0] m_tdata
);
	import vna_pkg::*;

	vna_cmd_t    cmd;
	vna_status_t st;

	vna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	vna_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the vertex normal accumulator: random meshes, unit-normal checks.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vna_pkg::*;

	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] va;
		logic [11:0] vb;
		logic [11:0] vc;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] pz;
	} mesh_cmd_t;

	typedef struct packed {
		logic [11:0] idx;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
	} normal_t;

	localparam longint SAT_HI = 64'sd549755813887;
	localparam longint SAT_LO = -64'sd549755813888;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	vertex_normal_accumulator_top u_dut (.*);

	always #1 clk = ~clk;

	longint pos_mem [4096][3];
	longint acc_mem [4096][3];
	bit written [4096];
	mesh_cmd_t cmd_queue [$];
	normal_t normals_due [$];
	int errors = 0;
	int idle_cycles = 0;
	bit stimulus_done = 0;
	bit sender_hold = 0;
	bit calm = 0;
	bit taken = 0;
	bit rx_held = 0;
	int rx_hold = 0;
	int rx_count = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint sat40(input longint a);
		if (a > SAT_HI) return SAT_HI;
		if (a < SAT_LO) return SAT_LO;
		return a;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned rem, root, b;
		rem = v; root = 0; b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic normal_t unit_of(input logic [11:0] idx);
		normal_t r;
		longint unsigned mag [3];
		longint unsigned top, sum, len, q;
		bit neg [3];
		r = '0;
		r.idx = idx;
		top = 0; sum = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = acc_mem[idx][i] < 0;
			mag[i] = neg[i] ? -acc_mem[idx][i] : acc_mem[idx][i];
			if (mag[i] > top) top = mag[i];
		end
		if (top == 0) return r;
		while (top >= (64'd1 << 31)) begin
			top >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (top < (64'd1 << 30)) begin
			top <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
		len = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * 16384 + (len >> 1)) / len;
			if (q > 16384) q = 16384;
			if (neg[i]) q = -q;
			if (i == 0) r.nx = q[15:0];
			else if (i == 1) r.ny = q[15:0];
			else r.nz = q[15:0];
		end
		return r;
	endfunction

	// advance the predicted mesh state by one accepted item
	task automatic predict_item(input mesh_cmd_t c);
		longint e1 [3], e2 [3], fn [3];
		if (c.mode == MODE_WRITE) begin
			pos_mem[c.va][0] = $signed(c.px);
			pos_mem[c.va][1] = $signed(c.py);
			pos_mem[c.va][2] = $signed(c.pz);
			for (int k = 0; k < 3; k++) acc_mem[c.va][k] = 0;
		end else if (c.mode == MODE_TRI) begin
			for (int k = 0; k < 3; k++) begin
				e1[k] = pos_mem[c.vb][k] - pos_mem[c.va][k];
				e2[k] = pos_mem[c.vc][k] - pos_mem[c.va][k];
			end
			fn[0] = e1[1] * e2[2] - e1[2] * e2[1];
			fn[1] = e1[2] * e2[0] - e1[0] * e2[2];
			fn[2] = e1[0] * e2[1] - e1[1] * e2[0];
			for (int k = 0; k < 3; k++) begin
				acc_mem[c.va][k] = sat40(acc_mem[c.va][k] + fn[k]);
				acc_mem[c.vb][k] = sat40(acc_mem[c.vb][k] + fn[k]);
				acc_mem[c.vc][k] = sat40(acc_mem[c.vc][k] + fn[k]);
			end
		end else if (c.mode == MODE_READ) begin
			normals_due.push_back(unit_of(c.va));
		end
	endtask

	// build a command item, with build-time bookkeeping of which vertices hold a position
	function automatic mesh_cmd_t make_cmd(input logic [1:0] m, input int a, input int b,
			input int c, input int x, input int y, input int z);
		mesh_cmd_t r;
		r = '{m, a[11:0], b[11:0], c[11:0], x[15:0], y[15:0], z[15:0]};
		if (m == MODE_WRITE) written[a] = 1;
		return r;
	endfunction

	function automatic int pick_vertex(input int lo, input int hi);
		int v;
		do v = $urandom_range(hi, lo); while (!written[v]);
		return v;
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(3, 0))
			0: return $urandom_range(65535, 0) - 32768;
			1: return $urandom_range(1, 0) ? 32767 : -32768;
			default: return $urandom_range(32000, 0) - 16000;
		endcase
	endfunction

	initial begin
		int a, b, c, base;
		// directed: extremes, saturation, degenerate and zero-length cases
		cmd_queue.push_back(make_cmd(MODE_WRITE, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_WRITE, 1, 0, 0, 32767, -32768, 0));
		cmd_queue.push_back(make_cmd(MODE_WRITE, 2, 0, 0, -32768, 32767, 32767));
		cmd_queue.push_back(make_cmd(MODE_WRITE, 4095, 4095, 4095, -1, -1, -32768));
		cmd_queue.push_back(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_TRI, 0, 1, 2, 0, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_READ, 1, 0, 0, 0, 0, 0));
		// enough repeats to drive the accumulators into saturation
		for (int i = 0; i < 200; i++)
			cmd_queue.push_back(make_cmd(MODE_TRI, 4095, 1, 2, 0, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_READ, 4095, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_TRI, 1, 1, 2, 0, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_READ, 2, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(2'd3, 4095, 4095, 4095, -1, -1, -1));
		cmd_queue.push_back(make_cmd(MODE_WRITE, 1, 0, 0, 5, 6, 7));
		cmd_queue.push_back(make_cmd(MODE_READ, 1, 0, 0, 0, 0, 0));
		// random meshes: small local patches of written vertices
		while (cmd_queue.size() < 1350) begin
			base = $urandom_range(4000, 0);
			for (int i = 0; i < 6; i++)
				cmd_queue.push_back(make_cmd(MODE_WRITE, base + $urandom_range(95, 0),
					$urandom_range(4095, 0), $urandom_range(4095, 0),
					rand_coord(), rand_coord(), rand_coord()));
			for (int i = 0; i < 8; i++) begin
				a = pick_vertex(base, base + 95);
				b = pick_vertex(base, base + 95);
				c = pick_vertex(base, base + 95);
				if ($urandom_range(9, 0) == 0) b = a;
				cmd_queue.push_back(make_cmd(MODE_TRI, a, b, c, $urandom(), $urandom(),
					$urandom()));
			end
			for (int i = 0; i < 3; i++)
				cmd_queue.push_back(make_cmd(MODE_READ, pick_vertex(base, base + 95),
					$urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
			if ($urandom_range(7, 0) == 0)
				cmd_queue.push_back(make_cmd(2'd3, $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom()));
		end
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	// note whether the offered item went in at the last rising edge
	always @(posedge clk) begin
		taken <= s_tvalid && s_tready;
	end

	// driver
	int sent = 0;
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || taken)) begin
			if (sent == 700 && !sender_hold) begin
				sender_hold <= 1'b1;
				s_tvalid <= 1'b0;
			end else if (sender_hold && normals_due.size() == 0) begin
				sender_hold <= 1'b0;
				sent <= sent + 1;
				s_tvalid <= 1'b0;
			end else if (!sender_hold && cmd_queue.size() != 0 &&
					(calm || $urandom_range(99, 0) >= 21)) begin
				mesh_cmd_t c;
				c = cmd_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= c.mode;
				s_tdata <= {4'd0, c.pz, c.py, c.px, c.vc, c.vb, c.va};
				sent <= sent + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		calm <= (sent > 300 && sent < 500);
	end

	// receiver, with one long hold-off
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (rx_count == 20 && !rx_held) begin
			rx_held <= 1'b1;
			rx_hold <= 3000;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(99, 0) >= 21;
		end
	end

	// monitor
	always @(posedge clk) begin
		normal_t got, want;
		bit moved;
		moved = 0;
		if (arst_n && s_tvalid && s_tready) begin
			predict_item({s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[35:24],
				s_tdata[51:36], s_tdata[67:52], s_tdata[83:68]});
			moved = 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			moved = 1;
			rx_count <= rx_count + 1;
			got = {m_tdata[11:0], m_tdata[27:12], m_tdata[43:28], m_tdata[59:44]};
			if (normals_due.size() == 0) begin
				report_mismatch("unexpected normal, index", got.idx, -1);
			end else begin
				want = normals_due.pop_front();
				if (got.idx !== want.idx) report_mismatch("vertex_index", got.idx, want.idx);
				if (got.nx !== want.nx)
					report_mismatch("normal_x", $signed(got.nx), $signed(want.nx));
				if (got.ny !== want.ny)
					report_mismatch("normal_y", $signed(got.ny), $signed(want.ny));
				if (got.nz !== want.nz)
					report_mismatch("normal_z", $signed(got.nz), $signed(want.nz));
			end
		end
		idle_cycles <= moved ? 0 : idle_cycles + 1;
	end

	initial begin
		int settle;
		settle = 0;
		wait (arst_n);
		// hold until all items are taken and every normal has come back
		while (!(cmd_queue.size() == 0 && !s_tvalid && normals_due.size() == 0 &&
				settle >= 200) && idle_cycles < WATCHDOG) begin
			@(posedge clk);
			if (cmd_queue.size() == 0 && !s_tvalid && normals_due.size() == 0)
				settle++;
			else
				settle = 0;
		end
		if (idle_cycles >= WATCHDOG) begin
			$display("vertex_normal_accumulator_top verification failed");
		end else if (errors == 0) begin
			$display("vertex_normal_accumulator_top verification clean");
		end else begin
			$display("vertex_normal_accumulator_top verification failed");
		end
		$finish;
	end
endmodule
